// ===== design/ddet_pkg.sv =====
package ddet_pkg;

  // func codes of an input request
  localparam logic [2:0] FUNC_LOAD_EXIST = 3'd0;
  localparam logic [2:0] FUNC_LOAD_AVAIL = 3'd1;
  localparam logic [2:0] FUNC_LOAD_ALLOC = 3'd2;
  localparam logic [2:0] FUNC_LOAD_REQ   = 3'd3;
  localparam logic [2:0] FUNC_RUN        = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  proc_id;
    logic [1:0]  res_id;
    logic [15:0] amount;
  } in_req_t;

  typedef struct packed {
    logic [2:0] deadlocked_proc;
    logic       deadlock_found;
    logic       last;
  } out_rsp_t;

endpackage

// ===== design/ddet_ram.sv =====
module ddet_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ddet_engine.sv =====
module ddet_engine #(
  parameter int NUM_PROCS   = 8,
  parameter int NUM_RES     = 4,
  parameter int COUNT_WIDTH = 16,
  localparam int AW = (NUM_PROCS * NUM_RES > 1) ? $clog2(NUM_PROCS * NUM_RES) : 1,
  localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1,
  localparam int RW = (NUM_RES > 1) ? $clog2(NUM_RES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [COUNT_WIDTH-1:0] existing_i [NUM_RES],
  input  logic [COUNT_WIDTH-1:0] available_i [NUM_RES],
  output logic [AW-1:0]          rd_addr_o,
  output logic                   req_ren_o,
  output logic                   alloc_ren_o,
  input  logic [COUNT_WIDTH-1:0] req_rdata_i,
  input  logic [COUNT_WIDTH-1:0] alloc_rdata_i,
  output logic                   done_o,
  output logic [NUM_PROCS-1:0]   finished_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_CHK_W = 3'd2;
  localparam logic [2:0] S_REL   = 3'd3;
  localparam logic [2:0] S_REL_W = 3'd4;
  localparam logic [2:0] S_ADV   = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [PW-1:0]          p_q, p_d;
  logic [RW-1:0]          r_q, r_d;
  logic [AW-1:0]          base_q, base_d;
  logic                   zero_phase_q, zero_phase_d;
  logic                   progress_q, progress_d;
  logic                   ok_q, ok_d;
  logic [NUM_PROCS-1:0]   finished_q, finished_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [RW-1:0]          rd_r_q, rd_r_d;
  logic                   done_q, done_d;
  logic [COUNT_WIDTH-1:0] work_q [NUM_RES];
  logic [COUNT_WIDTH-1:0] work_d [NUM_RES];

  logic                   r_last;
  logic                   skip;
  logic                   cmp_fail;
  logic [COUNT_WIDTH:0]   sum;
  logic                   sum_ok;

  assign r_last   = (r_q == RW'(NUM_RES - 1));
  assign skip     = !zero_phase_q && finished_q[p_q];
  // pre-pass looks for all-zero rows, sweeps compare against the work vector
  assign cmp_fail = zero_phase_q ? (req_rdata_i != '0) : (req_rdata_i > work_q[rd_r_q]);
  // release is capped at the existing count, no wrap
  assign sum      = {1'b0, work_q[rd_r_q]} + {1'b0, alloc_rdata_i};
  assign sum_ok   = (sum <= {1'b0, existing_i[rd_r_q]});

  assign rd_addr_o  = base_q + AW'(r_q);
  assign done_o     = done_q;
  assign finished_o = finished_q;

  always_comb begin
    state_d      = state_q;
    p_d          = p_q;
    r_d          = r_q;
    base_d       = base_q;
    zero_phase_d = zero_phase_q;
    progress_d   = progress_q;
    ok_d         = ok_q;
    finished_d   = finished_q;
    rd_vld_d     = 1'b0;
    rd_r_d       = rd_r_q;
    done_d       = 1'b0;
    work_d       = work_q;
    req_ren_o    = 1'b0;
    alloc_ren_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d      = S_CHK;
          p_d          = '0;
          r_d          = '0;
          base_d       = '0;
          zero_phase_d = 1'b1;
          progress_d   = 1'b0;
          ok_d         = 1'b1;
          finished_d   = '0;
          for (int i = 0; i < NUM_RES; i++) begin
            work_d[i] = available_i[i];
          end
        end
      end
      S_CHK: begin
        if ((r_q == '0) && skip) begin
          state_d = S_ADV;
        end else begin
          req_ren_o = 1'b1;
          rd_vld_d  = 1'b1;
          rd_r_d    = r_q;
          if (rd_vld_q && cmp_fail) begin
            ok_d = 1'b0;
          end
          if (r_last) begin
            r_d     = '0;
            state_d = S_CHK_W;
          end else begin
            r_d = r_q + RW'(1);
          end
        end
      end
      S_CHK_W: begin
        // last request word of the row lands here
        r_d = '0;
        if (ok_q && !cmp_fail) begin
          state_d = S_REL;
        end else begin
          state_d = S_ADV;
        end
      end
      S_REL: begin
        alloc_ren_o = 1'b1;
        rd_vld_d    = 1'b1;
        rd_r_d      = r_q;
        if (rd_vld_q && sum_ok) begin
          work_d[rd_r_q] = sum[COUNT_WIDTH-1:0];
        end
        if (r_last) begin
          r_d     = '0;
          state_d = S_REL_W;
        end else begin
          r_d = r_q + RW'(1);
        end
      end
      S_REL_W: begin
        if (sum_ok) begin
          work_d[rd_r_q] = sum[COUNT_WIDTH-1:0];
        end
        finished_d[p_q] = 1'b1;
        progress_d      = 1'b1;
        state_d         = S_ADV;
      end
      S_ADV: begin
        ok_d = 1'b1;
        r_d  = '0;
        if (p_q == PW'(NUM_PROCS - 1)) begin
          p_d    = '0;
          base_d = '0;
          if (zero_phase_q) begin
            zero_phase_d = 1'b0;
            progress_d   = 1'b0;
            state_d      = S_CHK;
          end else if (progress_q) begin
            progress_d = 1'b0;
            state_d    = S_CHK;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          p_d     = p_q + PW'(1);
          base_d  = base_q + AW'(NUM_RES);
          state_d = S_CHK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      p_q          <= '0;
      r_q          <= '0;
      base_q       <= '0;
      zero_phase_q <= 1'b0;
      progress_q   <= 1'b0;
      ok_q         <= 1'b0;
      finished_q   <= '0;
      rd_vld_q     <= 1'b0;
      rd_r_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      p_q          <= p_d;
      r_q          <= r_d;
      base_q       <= base_d;
      zero_phase_q <= zero_phase_d;
      progress_q   <= progress_d;
      ok_q         <= ok_d;
      finished_q   <= finished_d;
      rd_vld_q     <= rd_vld_d;
      rd_r_q       <= rd_r_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

endmodule

// ===== design/ddet_report.sv =====
module ddet_report
  import ddet_pkg::*;
#(
  parameter int NUM_PROCS = 8,
  localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 done_i,
  input  logic [NUM_PROCS-1:0] finished_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_rsp_t             out_rsp_o,
  output logic                 fin_o
);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_SCAN = 2'd1;
  localparam logic [1:0] R_FIN  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [PW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic [PW-1:0] pend_idx_q, pend_idx_d;
  logic          out_valid_q, out_valid_d;
  out_rsp_t      out_rsp_q, out_rsp_d;

  logic          free;
  logic          advance;
  logic [PW+2:0] pend_ext;

  assign free     = !out_valid_q || out_ready_i;
  assign pend_ext = {3'b000, pend_idx_q};

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    fin_o       = 1'b0;
    advance     = 1'b0;

    unique case (state_q)
      R_IDLE: begin
        if (done_i) begin
          state_d = R_SCAN;
          idx_d   = '0;
          pend_d  = 1'b0;
        end
      end
      R_SCAN: begin
        // hold one found process back so the final one can carry last
        if (!finished_i[idx_q]) begin
          if (!pend_q) begin
            pend_d     = 1'b1;
            pend_idx_d = idx_q;
            advance    = 1'b1;
          end else if (free) begin
            out_valid_d               = 1'b1;
            out_rsp_d.deadlocked_proc = pend_ext[2:0];
            out_rsp_d.deadlock_found  = 1'b1;
            out_rsp_d.last            = 1'b0;
            pend_idx_d                = idx_q;
            advance                   = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          if (idx_q == PW'(NUM_PROCS - 1)) begin
            state_d = R_FIN;
          end else begin
            idx_d = idx_q + PW'(1);
          end
        end
      end
      R_FIN: begin
        if (free) begin
          out_valid_d               = 1'b1;
          out_rsp_d.deadlocked_proc = pend_q ? pend_ext[2:0] : 3'd0;
          out_rsp_d.deadlock_found  = pend_q;
          out_rsp_d.last            = 1'b1;
          fin_o                     = 1'b1;
          state_d                   = R_IDLE;
        end
      end
      default: begin
        state_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= R_IDLE;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== design/deadlock_detector.sv =====
// Deadlock detector for NUM_PROCS processes over NUM_RES resource types.
//
// Input channel (in_valid_i/in_ready_o, in_req_i): each request either loads
// one count (existing vector, available vector, allocation or request matrix
// entry) or starts a detection run. Loads produce no result and are taken
// back to back. Loads with out-of-range indexes and unused func codes are
// dropped.
//
// A run copies the available vector into a work vector and walks the request
// and allocation RAMs one word per cycle: a row check reads the request row
// and then waits in S_CHK_W, a release reads the allocation row and then
// waits in S_REL_W, and a finished row is skipped in a sweep via S_ADV.
// One zero-row pre-pass is followed by sweeps until a sweep frees nothing,
// then the result scan reports. in_ready_o stays low from run accept until
// the final result is in the output register.
//
// Output channel (out_valid_o/out_ready_i, out_rsp_o): one result per
// deadlocked process in ascending order, or a single no-deadlock result;
// last marks the final one. A stalled receiver halts the report scan when it
// has a result to send; the output register holds its result. Reset clears
// all control state; the count storage is undefined until loaded.
module deadlock_detector
  import ddet_pkg::*;
#(
  parameter int NUM_PROCS   = 8,
  parameter int NUM_RES     = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  localparam int DEPTH = NUM_PROCS * NUM_RES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int RW    = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;

  logic                   busy_q, busy_d;
  logic                   accept;
  logic                   res_ok;
  logic                   proc_ok;
  logic [RW-1:0]          res_idx;
  logic [PW-1:0]          proc_idx;
  logic [COUNT_WIDTH-1:0] amount;
  logic [AW-1:0]          wr_addr;
  logic                   exist_we;
  logic                   avail_we;
  logic                   alloc_we;
  logic                   req_we;
  logic                   run_start;

  // small vectors stay in flops; the engine reads them by resource index
  logic [COUNT_WIDTH-1:0] existing_q [NUM_RES];
  logic [COUNT_WIDTH-1:0] available_q [NUM_RES];

  logic [AW-1:0]          rd_addr;
  logic                   req_ren;
  logic                   alloc_ren;
  logic [COUNT_WIDTH-1:0] req_rdata;
  logic [COUNT_WIDTH-1:0] alloc_rdata;
  logic                   eng_done;
  logic [NUM_PROCS-1:0]   finished;
  logic                   rpt_fin;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // index checks on the full port width, before narrowing
  assign res_ok   = (32'(in_req_i.res_id) < NUM_RES);
  assign proc_ok  = (32'(in_req_i.proc_id) < NUM_PROCS);
  assign res_idx  = RW'(in_req_i.res_id);
  assign proc_idx = PW'(in_req_i.proc_id);
  assign amount   = COUNT_WIDTH'(in_req_i.amount);
  assign wr_addr  = AW'(AW'(proc_idx) * AW'(NUM_RES) + AW'(res_idx));

  assign exist_we  = accept && (in_req_i.func == FUNC_LOAD_EXIST) && res_ok;
  assign avail_we  = accept && (in_req_i.func == FUNC_LOAD_AVAIL) && res_ok;
  assign alloc_we  = accept && (in_req_i.func == FUNC_LOAD_ALLOC) && res_ok && proc_ok;
  assign req_we    = accept && (in_req_i.func == FUNC_LOAD_REQ) && res_ok && proc_ok;
  assign run_start = accept && (in_req_i.func == FUNC_RUN);

  // busy from run accept until the final result is loaded for output
  always_comb begin
    busy_d = busy_q;
    if (run_start) begin
      busy_d = 1'b1;
    end else if (rpt_fin) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exist_we) begin
      existing_q[res_idx] <= amount;
    end
    if (avail_we) begin
      available_q[res_idx] <= amount;
    end
  end

  ddet_ram #(
    .DEPTH(DEPTH),
    .WIDTH(COUNT_WIDTH)
  ) u_alloc_ram (
    .clk_i  (clk_i),
    .we_i   (alloc_we),
    .waddr_i(wr_addr),
    .wdata_i(amount),
    .re_i   (alloc_ren),
    .raddr_i(rd_addr),
    .rdata_o(alloc_rdata)
  );

  ddet_ram #(
    .DEPTH(DEPTH),
    .WIDTH(COUNT_WIDTH)
  ) u_req_ram (
    .clk_i  (clk_i),
    .we_i   (req_we),
    .waddr_i(wr_addr),
    .wdata_i(amount),
    .re_i   (req_ren),
    .raddr_i(rd_addr),
    .rdata_o(req_rdata)
  );

  ddet_engine #(
    .NUM_PROCS  (NUM_PROCS),
    .NUM_RES    (NUM_RES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (run_start),
    .existing_i   (existing_q),
    .available_i  (available_q),
    .rd_addr_o    (rd_addr),
    .req_ren_o    (req_ren),
    .alloc_ren_o  (alloc_ren),
    .req_rdata_i  (req_rdata),
    .alloc_rdata_i(alloc_rdata),
    .done_o       (eng_done),
    .finished_o   (finished)
  );

  ddet_report #(
    .NUM_PROCS(NUM_PROCS)
  ) u_report (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .done_i     (eng_done),
    .finished_i (finished),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .fin_o      (rpt_fin)
  );

endmodule

// ===== design/ddet_checker.sv =====
module ddet_assert
  import ddet_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input in_req_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_rsp_t out_rsp_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
  else $error("result changed while stalled");

  // an accepted run drops the input ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.func == FUNC_RUN) |=> !in_ready_o)
  else $error("request taken during a run");

  // no-deadlock result names process 0 and closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.deadlock_found |->
      out_rsp_o.last && (out_rsp_o.deadlocked_proc == 3'd0))
  else $error("malformed no-deadlock result");

  // only a named process can be followed by more results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.last |-> out_rsp_o.deadlock_found)
  else $error("non-final result without a process");

endmodule

bind deadlock_detector ddet_assert u_ddet_assert (.*);

// ===== bench/ddet_checker.sv =====
module ddet_checker
  import ddet_pkg::*;
#(
  parameter int NUM_PROCS   = 8,
  parameter int NUM_RES     = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  in_req_t  in_req_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  out_rsp_t out_rsp_i,
  output int       mismatch_cnt_o,
  output int       pending_cnt_o
);

  localparam int MAX_PRINTS = 60;

  // shadow copy of the count storage
  logic [COUNT_WIDTH-1:0] exist_cnt [NUM_RES];
  logic [COUNT_WIDTH-1:0] avail_cnt [NUM_RES];
  logic [COUNT_WIDTH-1:0] alloc_cnt [NUM_PROCS][NUM_RES];
  logic [COUNT_WIDTH-1:0] need_cnt  [NUM_PROCS][NUM_RES];

  // one extra bit so release sums never wrap
  logic [COUNT_WIDTH:0]   work_cnt  [NUM_RES];
  logic [NUM_PROCS-1:0]   finish_mask;

  out_rsp_t blocked_q [$];
  int       mismatch_cnt;
  int       pending_cnt;

  assign mismatch_cnt_o = mismatch_cnt;
  assign pending_cnt_o  = pending_cnt;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_cnt < MAX_PRINTS) begin
      $display("mismatch @%0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    mismatch_cnt++;
  endtask

  // finish process p, handing back its allocation where the cap allows
  function automatic void free_row(input int p);
    logic [COUNT_WIDTH:0] sum;
    for (int r = 0; r < NUM_RES; r++) begin
      sum = work_cnt[r] + {1'b0, alloc_cnt[p][r]};
      if (sum <= {1'b0, exist_cnt[r]}) work_cnt[r] = sum;
    end
    finish_mask[p] = 1'b1;
  endfunction

  task automatic detect_deadlocks();
    bit       progress;
    bit       fit;
    bit       zero_row;
    int       total;
    int       seen;
    out_rsp_t rsp;
    for (int r = 0; r < NUM_RES; r++) work_cnt[r] = {1'b0, avail_cnt[r]};
    finish_mask = '0;
    // rows that ask for nothing go first, in index order
    for (int p = 0; p < NUM_PROCS; p++) begin
      zero_row = 1'b1;
      for (int r = 0; r < NUM_RES; r++) begin
        if (need_cnt[p][r] != '0) zero_row = 1'b0;
      end
      if (zero_row) free_row(p);
    end
    do begin
      progress = 1'b0;
      for (int p = 0; p < NUM_PROCS; p++) begin
        if (!finish_mask[p]) begin
          fit = 1'b1;
          for (int r = 0; r < NUM_RES; r++) begin
            if ({1'b0, need_cnt[p][r]} > work_cnt[r]) fit = 1'b0;
          end
          if (fit) begin
            free_row(p);
            progress = 1'b1;
          end
        end
      end
    end while (progress);
    total = 0;
    for (int p = 0; p < NUM_PROCS; p++) begin
      if (!finish_mask[p]) total++;
    end
    if (total == 0) begin
      rsp.deadlocked_proc = '0;
      rsp.deadlock_found  = 1'b0;
      rsp.last            = 1'b1;
      blocked_q.push_back(rsp);
    end else begin
      seen = 0;
      for (int p = 0; p < NUM_PROCS; p++) begin
        if (!finish_mask[p]) begin
          seen++;
          rsp.deadlocked_proc = 3'(p);
          rsp.deadlock_found  = 1'b1;
          rsp.last            = (seen == total);
          blocked_q.push_back(rsp);
        end
      end
    end
  endtask

  initial begin
    mismatch_cnt = 0;
    pending_cnt  = 0;
  end

  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        case (in_req_i.func)
          FUNC_LOAD_EXIST: begin
            if (in_req_i.res_id < NUM_RES) exist_cnt[in_req_i.res_id] = in_req_i.amount;
          end
          FUNC_LOAD_AVAIL: begin
            if (in_req_i.res_id < NUM_RES) avail_cnt[in_req_i.res_id] = in_req_i.amount;
          end
          FUNC_LOAD_ALLOC: begin
            if (in_req_i.res_id < NUM_RES && in_req_i.proc_id < NUM_PROCS) begin
              alloc_cnt[in_req_i.proc_id][in_req_i.res_id] = in_req_i.amount;
            end
          end
          FUNC_LOAD_REQ: begin
            if (in_req_i.res_id < NUM_RES && in_req_i.proc_id < NUM_PROCS) begin
              need_cnt[in_req_i.proc_id][in_req_i.res_id] = in_req_i.amount;
            end
          end
          FUNC_RUN: detect_deadlocks();
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (blocked_q.size() == 0) begin
          report_mismatch("unexpected result, proc", 8'(out_rsp_i.deadlocked_proc), 8'd0);
        end else begin
          want = blocked_q.pop_front();
          if (out_rsp_i.deadlocked_proc !== want.deadlocked_proc) begin
            report_mismatch("deadlocked_proc", 8'(out_rsp_i.deadlocked_proc),
                            8'(want.deadlocked_proc));
          end
          if (out_rsp_i.deadlock_found !== want.deadlock_found) begin
            report_mismatch("deadlock_found", 8'(out_rsp_i.deadlock_found),
                            8'(want.deadlock_found));
          end
          if (out_rsp_i.last !== want.last) begin
            report_mismatch("last", 8'(out_rsp_i.last), 8'(want.last));
          end
        end
      end
      pending_cnt = blocked_q.size();
    end
  end

endmodule

// ===== bench/tb_deadlock_detector.sv =====
module tb_deadlock_detector;
  import ddet_pkg::*;

  localparam int NUM_PROCS    = 8;
  localparam int NUM_RES      = 4;
  localparam int COUNT_WIDTH  = 16;
  localparam int RANDOM_REQS  = 330;  // random requests that the block acts on
  localparam int MAX_GAP      = 14;   // most idle cycles drawn per request, either side
  localparam int STALL_AT     = 30;   // result count at which the receiver goes quiet
  localparam int STALL_CYCLES = 1500; // length of that hold-off
  localparam int IDLE_LIMIT   = 8000; // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 64;

  // func codes the block ignores
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_ready;
  out_rsp_t out_rsp;

  int mismatch_cnt;
  int pending_cnt;
  int sent_cnt;   // requests with a live func code
  int rsp_taken;
  bit in_calm;    // calm stretches: no idle cycles on that side
  bit out_calm;

  deadlock_detector #(
    .NUM_PROCS  (NUM_PROCS),
    .NUM_RES    (NUM_RES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  ddet_checker #(
    .NUM_PROCS  (NUM_PROCS),
    .NUM_RES    (NUM_RES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_req_i      (in_req),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_rsp_i     (out_rsp),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_cnt_o (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one request: optional idle gap, then hold valid and payload
  // until the block takes it. Entered and left at a falling edge; with no
  // gap, valid stays high straight into the next request.
  task automatic send_req(input in_req_t req);
    int gap;
    if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_req   = req;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    if (req.func <= FUNC_RUN) sent_cnt++;
  endtask

  task automatic issue(input logic [2:0] func, input logic [2:0] proc,
                       input logic [1:0] res, input logic [15:0] amount);
    in_req_t req;
    req.func    = func;
    req.proc_id = proc;
    req.res_id  = res;
    req.amount  = amount;
    send_req(req);
  endtask

  // Run requests carry random filler in the unused fields.
  task automatic issue_run();
    issue(FUNC_RUN, 3'($urandom), 2'($urandom), 16'($urandom));
  endtask

  // Counts are kept mostly small so that requests and releases interact;
  // now and then an extreme or a full-range value.
  function automatic logic [15:0] pick_amount(input logic [2:0] func);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 16'hFFFF;
    if (sel == 1) return 16'h0000;
    if (sel == 2) return 16'($urandom);
    case (func)
      FUNC_LOAD_EXIST: return 16'($urandom_range(3, 24));
      FUNC_LOAD_AVAIL: return 16'($urandom_range(0, 5));
      FUNC_LOAD_ALLOC: return 16'($urandom_range(0, 4));
      default:         return (sel < 8) ? 16'h0000 : 16'($urandom_range(1, 3));
    endcase
  endfunction

  // A handful of loads, sometimes a cleared request row, then usually a run.
  // Some sequences end without a run, and a few spare codes slip in as noise.
  task automatic random_scenario();
    int         n;
    int         p;
    logic [2:0] func;
    n = $urandom_range(1, 10);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) begin
        issue(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
              3'($urandom), 2'($urandom), 16'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0:       func = FUNC_LOAD_EXIST;
          1:       func = FUNC_LOAD_AVAIL;
          2:       func = FUNC_LOAD_ALLOC;
          default: func = FUNC_LOAD_REQ;
        endcase
        issue(func, 3'($urandom_range(0, NUM_PROCS - 1)),
              2'($urandom_range(0, NUM_RES - 1)), pick_amount(func));
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      p = $urandom_range(0, NUM_PROCS - 1);
      for (int r = 0; r < NUM_RES; r++) issue(FUNC_LOAD_REQ, 3'(p), 2'(r), 16'h0000);
    end
    if ($urandom_range(0, 9) != 0) issue_run();
  endtask

  // Receiver: random readiness per result, calm stretches, and one long
  // hold-off so the output register fills and the input stalls behind it.
  initial begin
    int gap;
    out_ready = 1'b0;
    rsp_taken = 0;
    out_calm  = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
      gap = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready = 1'b1;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
      rsp_taken++;
      if (rsp_taken == STALL_AT) begin
        out_ready = 1'b0;
        repeat (STALL_CYCLES) @(negedge clk_i);
      end
    end
  end

  // Watchdog: a long stretch without a handshake on either side ends the run.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_valid = 1'b0;
    in_req   = '0;
    in_calm  = 1'b0;
    sent_cnt = 0;
    rst_ni   = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill every entry before the first run; nothing is ever read unloaded.
    for (int r = 0; r < NUM_RES; r++) issue(FUNC_LOAD_EXIST, 3'd0, 2'(r), 16'd40);
    for (int r = 0; r < NUM_RES; r++) issue(FUNC_LOAD_AVAIL, 3'd0, 2'(r), 16'd1);
    for (int p = 0; p < NUM_PROCS; p++) begin
      for (int r = 0; r < NUM_RES; r++) begin
        issue(FUNC_LOAD_ALLOC, 3'(p), 2'(r), 16'((p + r) % 3));
        issue(FUNC_LOAD_REQ, 3'(p), 2'(r), 16'h0000);
      end
    end

    // Directed: all rows zero, so the pre-pass frees everyone.
    issue_run();
    // Every process asks for the maximum with little available: all deadlocked.
    for (int p = 0; p < NUM_PROCS; p++) issue(FUNC_LOAD_REQ, 3'(p), 2'd0, 16'hFFFF);
    issue_run();
    // Existing and available at the maximum: everyone fits, and every release with
    // a nonzero allocation on that column would overflow the cap, so it is skipped.
    issue(FUNC_LOAD_EXIST, 3'd0, 2'd0, 16'hFFFF);
    issue(FUNC_LOAD_AVAIL, 3'd0, 2'd0, 16'hFFFF);
    issue_run();
    // Same again: a run must leave the available vector untouched.
    issue_run();
    // Spare func codes with full fields: dropped.
    for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++) begin
      issue(3'(f), 3'd7, 2'd3, 16'hFFFF);
    end
    // Highest indexes, a request just over what is available.
    issue(FUNC_LOAD_AVAIL, 3'd0, 2'd3, 16'h0000);
    issue(FUNC_LOAD_REQ, 3'd7, 2'd3, 16'h0001);
    issue_run();

    sent_cnt = 0;
    while (sent_cnt < RANDOM_REQS) random_scenario();
    issue_run();
    in_valid = 1'b0;

    wait (pending_cnt == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
